// ----- design/ipv6bp_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv6bp_pkg
// Shared types, character codes and digit helpers for the bracketed IPv6
// address parser.
// ----------------------------------------------------------------------------
package ipv6bp_pkg;

    localparam int MAX_GROUPS      = 8;
    localparam int GROUP_W         = 16;
    localparam int PORT_W          = 16;
    localparam int GI_W            = 4;
    localparam int GIX_W           = 3;
    localparam int DEF_GROUPS      = 8;
    localparam int DEF_DIGIT_SLOTS = 6;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

    typedef enum logic [1:0] {
        ST_MORE    = 2'd0,
        ST_END     = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_OPEN   = 2'd1,
        PH_CLOSED = 2'd2
    } phase_t;

    typedef logic [MAX_GROUPS-1:0][GROUP_W-1:0] groups_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       abort;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    typedef struct packed {
        status_t             status;
        groups_t             groups;
        logic [PORT_W-1:0]   port_number;
    } result_t;

    function automatic logic is_dec(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    // letters map through the low nibble: 'a'/'A' carry 1 there
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        if (is_dec(c))
        begin
            n = c[3:0];
        end
        else if (is_hex(c))
        begin
            n = c[3:0] + HEX_LETTER_OFS;
        end
        else
        begin
            n = 4'd0;
        end
        return n;
    endfunction

endpackage

// ----- design/ipv6bp_ifs.sv -----
// ----------------------------------------------------------------------------
// ipv6bp channel interfaces
// Character input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface ipv6bp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       abort;

    modport source (output valid, output char_code, output abort, input ready);
    modport sink   (input valid, input char_code, input abort, output ready);
endinterface

interface ipv6bp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] group_0;
    logic [15:0] group_1;
    logic [15:0] group_2;
    logic [15:0] group_3;
    logic [15:0] group_4;
    logic [15:0] group_5;
    logic [15:0] group_6;
    logic [15:0] group_7;
    logic [15:0] port_number;

    modport source (output valid, output status, output group_0, output group_1,
                    output group_2, output group_3, output group_4, output group_5,
                    output group_6, output group_7, output port_number, input ready);
    modport sink   (input valid, input status, input group_0, input group_1,
                    input group_2, input group_3, input group_4, input group_5,
                    input group_6, input group_7, input port_number, output ready);
endinterface

interface ipv6bp_cfg_if;
    logic valid;
    logic ready;
    logic expect_port;

    modport source (output valid, output expect_port, input ready);
    modport sink   (input valid, input expect_port, output ready);
endinterface

// ----- design/ipv6bp_in_stage.sv -----
// ----------------------------------------------------------------------------
// ipv6bp_in_stage
// Input register for one character beat; refills while the held beat drains.
// ----------------------------------------------------------------------------
module ipv6bp_in_stage
    import ipv6bp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  item_t  in_item,
    output logic   in_ready,
    input  logic   take,
    output stage_t stage
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// ----- design/ipv6bp_gap_expand.sv -----
// ----------------------------------------------------------------------------
// ipv6bp_gap_expand
// Widen the '::' gap: repeat the gap group and move later groups to the end.
// ----------------------------------------------------------------------------
module ipv6bp_gap_expand
    import ipv6bp_pkg::*;
#(
    parameter int GROUPS = DEF_GROUPS
)
(
    input  groups_t          grp_in,
    input  logic [GI_W-1:0]  count,
    input  logic [GI_W-1:0]  gap,
    output groups_t          grp_out,
    output logic [GI_W-1:0]  count_out
);

    logic            active;
    logic [GI_W-1:0] g;
    logic [GI_W-1:0] shift;
    logic [GI_W:0]   hi;

    assign active    = (count != '0) && (count < GI_W'(GROUPS));
    assign g         = (gap >= count) ? count - 1'b1 : gap;
    assign shift     = GI_W'(GROUPS) - count;
    assign hi        = {1'b0, g} + {1'b0, shift};
    assign count_out = active ? GI_W'(GROUPS) : count;

    always_comb
    begin
        for (int i = 0; i < MAX_GROUPS; i++)
        begin
            grp_out[i] = grp_in[i];
            if (active && (i < GROUPS) && (GI_W'(i) >= g))
            begin
                if ((GI_W+1)'(i) <= hi)
                begin
                    grp_out[i] = grp_in[g[GIX_W-1:0]];
                end
                else
                begin
                    grp_out[i] = grp_in[GIX_W'(GI_W'(i) - shift)];
                end
            end
        end
    end

endmodule

// ----- design/ipv6bp_engine.sv -----
// ----------------------------------------------------------------------------
// ipv6bp_engine
// Parse state, per-character update and result register.
// ----------------------------------------------------------------------------
module ipv6bp_engine
    import ipv6bp_pkg::*;
#(
    parameter int GROUPS      = DEF_GROUPS,
    parameter int DIGIT_SLOTS = DEF_DIGIT_SLOTS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  stage_t  stage,
    input  logic    expect_port,
    input  logic    out_ready,
    output logic    take,
    output logic    res_valid,
    output result_t res
);

    localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);

    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [GI_W-1:0]   gi_reg,    gi_next;
    logic [GI_W-1:0]   gap_reg,   gap_next;
    phase_t            phase_reg, phase_next;
    groups_t           groups_reg, groups_next;
    logic [PORT_W-1:0] port_reg,  port_next;
    logic [GROUP_W-1:0] hex_reg,  hex_next;
    logic [PORT_W-1:0] dec_reg,   dec_next;
    logic              res_valid_reg;
    result_t           res_reg;
    status_t           st;

    logic              can_close;
    groups_t           cl_groups;
    logic [GI_W-1:0]   cl_gi;
    logic [GI_W-1:0]   cl_gap;
    groups_t           ex_groups;
    logic [GI_W-1:0]   ex_gi;
    logic [7:0]        c;

    assign c    = stage.item.char_code;
    assign take = stage.valid && (!res_valid_reg || out_ready);

    assign can_close = gi_reg < GI_W'(GROUPS);

    always_comb
    begin
        cl_groups = groups_reg;
        cl_gi     = gi_reg;
        cl_gap    = gap_reg;
        if (can_close)
        begin
            cl_groups[gi_reg[GIX_W-1:0]] = hex_reg;
            cl_gi = gi_reg + 1'b1;
            if (cnt_reg == '0)
            begin
                cl_gap = gi_reg;
            end
        end
    end

    ipv6bp_gap_expand #(
        .GROUPS    (GROUPS)
    ) u_gap_expand (
        .grp_in    (cl_groups),
        .count     (cl_gi),
        .gap       (cl_gap),
        .grp_out   (ex_groups),
        .count_out (ex_gi)
    );

    always_comb
    begin
        cnt_next    = cnt_reg;
        gi_next     = gi_reg;
        gap_next    = gap_reg;
        phase_next  = phase_reg;
        groups_next = groups_reg;
        port_next   = port_reg;
        hex_next    = hex_reg;
        dec_next    = dec_reg;
        st          = ST_INVALID;

        if (stage.item.abort)
        begin
            phase_next = PH_IDLE;
        end
        else if (c == CH_LBRACK)
        begin
            cnt_next    = '0;
            gi_next     = '0;
            gap_next    = '0;
            port_next   = '0;
            hex_next    = '0;
            dec_next    = '0;
            groups_next = '0;
            phase_next  = PH_OPEN;
            st          = ST_MORE;
        end
        else if (c == CH_COLON)
        begin
            if (can_close)
            begin
                groups_next = cl_groups;
                gi_next     = cl_gi;
                gap_next    = cl_gap;
                cnt_next    = '0;
                hex_next    = '0;
                dec_next    = '0;
            end
            st = ST_MORE;
        end
        else if (is_hex(c))
        begin
            if (cnt_reg < CNT_W'(DIGIT_SLOTS))
            begin
                cnt_next = cnt_reg + 1'b1;
                hex_next = {hex_reg[GROUP_W-5:0], hex_nibble(c)};
                if (is_dec(c))
                begin
                    dec_next = {dec_reg[PORT_W-4:0], 3'b000} + {dec_reg[PORT_W-2:0], 1'b0}
                               + PORT_W'(c - CH_ZERO);
                end
                st = ST_MORE;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end
        else if (c == CH_RBRACK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                if (can_close)
                begin
                    gap_next = cl_gap;
                    cnt_next = '0;
                    hex_next = '0;
                    dec_next = '0;
                end
                groups_next = ex_groups;
                gi_next     = ex_gi;
                if (expect_port)
                begin
                    phase_next = PH_CLOSED;
                    st         = ST_MORE;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    st         = ST_END;
                end
            end
        end
        else if ((c == CH_SLASH) || (c == CH_DQUOTE))
        begin
            if (expect_port)
            begin
                port_next = dec_reg;
            end
            if ((phase_reg == PH_CLOSED) && expect_port)
            begin
                st = ST_END;
            end
            phase_next = PH_IDLE;
        end
        else
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            gi_reg        <= '0;
            gap_reg       <= '0;
            phase_reg     <= PH_IDLE;
            groups_reg    <= '0;
            port_reg      <= '0;
            hex_reg       <= '0;
            dec_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                cnt_reg    <= cnt_next;
                gi_reg     <= gi_next;
                gap_reg    <= gap_next;
                phase_reg  <= phase_next;
                groups_reg <= groups_next;
                port_reg   <= port_next;
                hex_reg    <= hex_next;
                dec_reg    <= dec_next;
            end
            res_valid_reg <= take || (res_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg.status      <= st;
            res_reg.groups      <= groups_next;
            res_reg.port_number <= port_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_gi_range: assert property (@(posedge clk) disable iff (!rst_n)
        gi_reg <= GI_W'(GROUPS))
        else $error("group index beyond group count");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DIGIT_SLOTS))
        else $error("digit count beyond digit slots");

    a_closed_full: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CLOSED) |-> (gi_reg == GI_W'(GROUPS)))
        else $error("address closed with groups missing");

    a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (gap_reg == '0) || (gap_reg < gi_reg))
        else $error("gap index at or past group index");

endmodule

// ----- design/ipv6_bracket_address_parser_core.sv -----
// ----------------------------------------------------------------------------
// ipv6_bracket_address_parser_core
// Parses [ipv6-address]:port text one character per beat.
// An accepted character is held in the input register, then its result in the result register.
// Throughput: one character per cycle while the result output is not stalled, set by the single-pass parse stage.
// Reset clears the parse state, groups and port; expect_port resets to 1.
// ----------------------------------------------------------------------------
module ipv6_bracket_address_parser_core
    import ipv6bp_pkg::*;
#(
    parameter int GROUPS      = DEF_GROUPS,
    parameter int DIGIT_SLOTS = DEF_DIGIT_SLOTS
)
(
    input  logic            clk,
    input  logic            rst_n,
    ipv6bp_char_if.sink     chars,
    ipv6bp_result_if.source results,
    ipv6bp_cfg_if.sink      cfg
);

    logic    expect_port_reg;
    item_t   in_item;
    stage_t  stage;
    logic    take;
    result_t res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_port_reg <= 1'b1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            expect_port_reg <= cfg.expect_port;
        end
    end

    assign in_item.char_code = chars.char_code;
    assign in_item.abort     = chars.abort;

    ipv6bp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_item  (in_item),
        .in_ready (chars.ready),
        .take     (take),
        .stage    (stage)
    );

    ipv6bp_engine #(
        .GROUPS      (GROUPS),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .expect_port (expect_port_reg),
        .out_ready   (results.ready),
        .take        (take),
        .res_valid   (results.valid),
        .res         (res)
    );

    assign results.status      = res.status;
    assign results.group_0     = res.groups[0];
    assign results.group_1     = res.groups[1];
    assign results.group_2     = res.groups[2];
    assign results.group_3     = res.groups[3];
    assign results.group_4     = res.groups[4];
    assign results.group_5     = res.groups[5];
    assign results.group_6     = res.groups[6];
    assign results.group_7     = res.groups[7];
    assign results.port_number = res.port_number;

endmodule
